// ===== rtl/mttm_pkg.sv =====
`default_nettype none

package mttm_pkg;

    localparam logic [1:0] KIND_SILENT = 2'd0;
    localparam logic [1:0] KIND_SINE   = 2'd1;
    localparam logic [1:0] KIND_SQUARE = 2'd2;

    localparam logic OP_SET    = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic [6:0] GAIN_MAX   = 7'd100;
    localparam logic [6:0] GAIN_RESET = 7'd50;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] step;
        logic [6:0]  gain;
    } track_cfg_t;

    localparam track_cfg_t CFG_RESET = '{kind: KIND_SILENT, step: 24'd0, gain: GAIN_RESET};

    // weighted harmonic sum and accumulator widths
    localparam int WSUM_W = 21;
    localparam int PROD_W = 29;
    localparam int ACC_W  = 36;

    localparam logic signed [WSUM_W-1:0] W_FUND  = 21'sd15;
    localparam logic signed [WSUM_W-1:0] W_THIRD = 21'sd5;
    localparam logic signed [WSUM_W-1:0] W_FIFTH = 21'sd3;

    // rounding division of the magnitude by 1500
    localparam int DIVIDEND_W = 27;
    localparam int QUOT_W     = 17;
    localparam int RECIP_W    = 28;
    localparam int DIV_SHIFT  = 38;
    // ceil(2^38 / 1500), exact for any 27-bit dividend
    localparam logic [RECIP_W-1:0] DIV_RECIP = 28'd183251938;
    localparam logic [ACC_W-1:0] ROUND_HALF = 36'd750;
    localparam logic [ACC_W-1:0] MAG_LIMIT  = 36'd98304000;

    localparam logic [QUOT_W-1:0] Q_POS_MAX = 17'd32767;
    localparam logic [QUOT_W-1:0] Q_NEG_MAX = 17'd32768;
    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    // sine table construction
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;

endpackage

`default_nettype wire

// ===== rtl/mttm_track_mem.sv =====
`default_nettype none

module mttm_track_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8,
    parameter int AW = 3,
    parameter logic [WIDTH-1:0] INIT = '0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] ram [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ram[rd_addr];
        end
    end

    // entries never written read back as their reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : INIT;

endmodule

`default_nettype wire

// ===== rtl/mttm_sine_rom.sv =====
`default_nettype none

module mttm_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int RAW = 10
) (
    input  wire logic               clk,
    input  wire logic [RAW-1:0]     addr,
    output logic signed [15:0]      data
);

    typedef logic signed [15:0] rom_t [SINE_TABLE_DEPTH];

    // taylor series through x^13 in q30 on the reflected quarter wave
    function automatic logic signed [15:0] sine_entry(input int unsigned i);
        logic [63:0] f;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] mag;
        logic signed [63:0] sum;
        f = (64'(i) << 32) / 64'(SINE_TABLE_DEPTH);
        quad = (f >> 30) & 64'd3;
        r = f & (mttm_pkg::Q30_ONE - 64'd1);
        if (quad[0])
        begin
            r = mttm_pkg::Q30_ONE - r;
        end
        x = (r * mttm_pkg::HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        sum = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum = sum + $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        mag = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767)
        begin
            mag = 64'd32767;
        end
        return (quad >= 64'd2) ? 16'(-mag) : 16'(mag);
    endfunction

    function automatic rom_t build_rom();
        rom_t tab;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            tab[i] = sine_entry(i);
        end
        return tab;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic signed [15:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= SINE_ROM[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== rtl/mttm_div.sv =====
`default_nettype none

module mttm_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                go,
    input  wire logic [mttm_pkg::DIVIDEND_W-1:0]     dividend,
    output logic                                     done,
    output logic      [mttm_pkg::QUOT_W-1:0]         quotient
);

    localparam int PROD_W = mttm_pkg::DIVIDEND_W + mttm_pkg::RECIP_W;

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              done_reg, done_next;

    // multiply by the scaled reciprocal of 1500, the top bits hold the quotient
    assign prod_next = PROD_W'(dividend) * PROD_W'(mttm_pkg::DIV_RECIP);
    assign done_next = go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            prod_reg <= prod_next;
        end
    end

    assign done     = done_reg;
    assign quotient = prod_reg[mttm_pkg::DIV_SHIFT +: mttm_pkg::QUOT_W];

endmodule

`default_nettype wire

// ===== rtl/multi_track_tone_mixer_unit.sv =====
`default_nettype none

// channel   dir  handshake                  fields
// command   in   start, taken when !busy    operation, track_index, tone_kind, phase_step, volume
// result    out  done, one-cycle strobe     mix_sample, clipped
//
// a set beat reads the track settings, then writes the new settings.
// a render beat steps through every track: silent and unused-kind tracks only read their settings,
// sine tracks add one sine table read and square tracks three, set by the one-port track memories
// and the single sine table port; it then sums, rounds and divides by 1500 with a reciprocal
// multiply, skipping the divide when saturated.
// after reset all tracks read silent with gain 50 through per-entry valid flags; no clearing pass.
// busy is low again in the cycle done strobes; the receiver cannot stall the result.

module multi_track_tone_mixer_unit #(
    parameter int TRACKS = 8,
    parameter int PHASE_BITS = 24,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               operation,
    input  wire logic [2:0]         track_index,
    input  wire logic [1:0]         tone_kind,
    input  wire logic [23:0]        phase_step,
    input  wire logic [7:0]         volume,
    output logic                    done,
    output logic signed [15:0]      mix_sample,
    output logic                    clipped
);

    localparam int AW     = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int PW     = PHASE_BITS;
    localparam int RAW    = $clog2(SINE_TABLE_DEPTH);
    localparam int IDXP_W = PW + 13;
    localparam int SH_UP  = (PW >= 24) ? (PW - 24) : 0;
    localparam int SH_DN  = (PW < 24) ? (24 - PW) : 0;
    localparam logic [AW-1:0] LAST_TRACK = AW'(TRACKS - 1);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b000000000001,
        ST_SET_WR   = 12'b000000000010,
        ST_RD       = 12'b000000000100,
        ST_LD       = 12'b000000001000,
        ST_H1       = 12'b000000010000,
        ST_H3       = 12'b000000100000,
        ST_H5       = 12'b000001000000,
        ST_WB       = 12'b000010000000,
        ST_SUM      = 12'b000100000000,
        ST_PREP     = 12'b001000000000,
        ST_DIV_GO   = 12'b010000000000,
        ST_DIV_WAIT = 12'b100000000000
    } state_t;

    function automatic logic [RAW-1:0] rom_index(input logic [PW-1:0] ph);
        logic [IDXP_W-1:0] p;
        p = IDXP_W'(ph) * IDXP_W'(SINE_TABLE_DEPTH);
        return RAW'(p >> PW);
    endfunction

    function automatic logic [PW-1:0] scale_step(input logic [23:0] st);
        logic [55:0] w;
        w = (56'(st) << SH_UP) >> SH_DN;
        return PW'(w);
    endfunction

    state_t                       state_reg, state_next;
    logic [AW-1:0]                addr_reg, addr_next;
    mttm_pkg::track_cfg_t         set_cfg_reg, set_cfg_next;
    logic [1:0]                   kind_reg, kind_next;
    logic [6:0]                   gain_reg, gain_next;
    logic [PW-1:0]                sstep_reg, sstep_next;
    logic [PW-1:0]                pf_reg, pf_next;
    logic [PW-1:0]                p3_reg, p3_next;
    logic [PW-1:0]                p5_reg, p5_next;
    logic signed [mttm_pkg::WSUM_W-1:0] wsum_reg, wsum_next;
    logic signed [mttm_pkg::ACC_W-1:0]  prod_reg, prod_next;
    logic signed [mttm_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic                         neg_reg, neg_next;
    logic [mttm_pkg::ACC_W-1:0]   mag_reg, mag_next;
    logic                         done_reg, done_next;
    logic signed [15:0]           sample_reg, sample_next;
    logic                         clipped_reg, clipped_next;

    logic [6:0]                   idx_ext;
    logic [AW-1:0]                in_addr;
    logic                         in_range;
    logic [6:0]                   gain_clamped;

    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic                         cfg_wr_en;
    mttm_pkg::track_cfg_t         cfg_rd;
    logic                         ph_wr_en;
    logic [3*PW-1:0]              ph_wdata;
    logic [3*PW-1:0]              ph_rd;
    logic [RAW-1:0]               rom_addr;
    logic signed [15:0]           rom_data;
    logic signed [mttm_pkg::WSUM_W-1:0] s_ext;
    logic signed [mttm_pkg::PROD_W-1:0] mul;
    logic                         div_go;
    logic                         div_done;
    logic [mttm_pkg::QUOT_W-1:0]  div_quot;
    logic [mttm_pkg::QUOT_W-1:0]  neg_quot;

    assign idx_ext      = {4'b0000, track_index};
    assign in_addr      = idx_ext[AW-1:0];
    assign in_range     = (idx_ext < 7'(TRACKS));
    assign gain_clamped = (volume > {1'b0, mttm_pkg::GAIN_MAX}) ? mttm_pkg::GAIN_MAX : volume[6:0];

    assign s_ext    = mttm_pkg::WSUM_W'(rom_data);
    assign mul      = wsum_reg * $signed({1'b0, gain_reg});
    assign neg_quot = '0 - div_quot;

    mttm_track_mem #(
        .DEPTH (TRACKS),
        .WIDTH ($bits(mttm_pkg::track_cfg_t)),
        .AW    (AW),
        .INIT  (mttm_pkg::CFG_RESET)
    ) u_cfg_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_wr_en),
        .wr_addr (addr_reg),
        .wr_data (set_cfg_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (cfg_rd)
    );

    mttm_track_mem #(
        .DEPTH (TRACKS),
        .WIDTH (3 * PW),
        .AW    (AW),
        .INIT  ('0)
    ) u_phase_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ph_wr_en),
        .wr_addr (addr_reg),
        .wr_data (ph_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ph_rd)
    );

    mttm_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .RAW              (RAW)
    ) u_sine_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    mttm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (mag_reg[mttm_pkg::DIVIDEND_W-1:0]),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        set_cfg_next = set_cfg_reg;
        kind_next    = kind_reg;
        gain_next    = gain_reg;
        sstep_next   = sstep_reg;
        pf_next      = pf_reg;
        p3_next      = p3_reg;
        p5_next      = p5_reg;
        wsum_next    = wsum_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        done_next    = 1'b0;
        sample_next  = sample_reg;
        clipped_next = clipped_reg;
        rd_en        = 1'b0;
        rd_addr      = addr_reg;
        cfg_wr_en    = 1'b0;
        ph_wr_en     = 1'b0;
        ph_wdata     = {pf_reg, p3_reg, p5_reg};
        rom_addr     = rom_index(pf_reg);
        div_go       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = in_addr;
                if (start)
                begin
                    if (operation == mttm_pkg::OP_SET)
                    begin
                        if (in_range)
                        begin
                            rd_en        = 1'b1;
                            addr_next    = in_addr;
                            set_cfg_next = '{kind: tone_kind, step: phase_step,
                                             gain: gain_clamped};
                            state_next   = ST_SET_WR;
                        end
                    end
                    else
                    begin
                        addr_next  = '0;
                        acc_next   = '0;
                        prod_next  = '0;
                        state_next = ST_RD;
                    end
                end
            end
            ST_SET_WR:
            begin
                cfg_wr_en = 1'b1;
                // a new kind restarts all three phases
                if (cfg_rd.kind != set_cfg_reg.kind)
                begin
                    ph_wr_en = 1'b1;
                    ph_wdata = '0;
                end
                state_next = ST_IDLE;
            end
            ST_RD:
            begin
                rd_en      = 1'b1;
                acc_next   = acc_reg + prod_reg;
                state_next = ST_LD;
            end
            ST_LD:
            begin
                kind_next  = cfg_rd.kind;
                gain_next  = cfg_rd.gain;
                sstep_next = scale_step(cfg_rd.step);
                pf_next    = ph_rd[3*PW-1 -: PW];
                p3_next    = ph_rd[2*PW-1 -: PW];
                p5_next    = ph_rd[PW-1:0];
                rom_addr   = rom_index(ph_rd[3*PW-1 -: PW]);
                if (cfg_rd.kind == mttm_pkg::KIND_SINE || cfg_rd.kind == mttm_pkg::KIND_SQUARE)
                begin
                    state_next = ST_H1;
                end
                else
                begin
                    prod_next = '0;
                    if (addr_reg == LAST_TRACK)
                    begin
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        addr_next  = addr_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_H1:
            begin
                wsum_next = s_ext * mttm_pkg::W_FUND;
                if (kind_reg == mttm_pkg::KIND_SQUARE)
                begin
                    rom_addr   = rom_index(p3_reg);
                    state_next = ST_H3;
                end
                else
                begin
                    state_next = ST_WB;
                end
            end
            ST_H3:
            begin
                wsum_next  = wsum_reg + s_ext * mttm_pkg::W_THIRD;
                rom_addr   = rom_index(p5_reg);
                state_next = ST_H5;
            end
            ST_H5:
            begin
                wsum_next  = wsum_reg + s_ext * mttm_pkg::W_FIFTH;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                prod_next = mttm_pkg::ACC_W'(mul);
                ph_wr_en  = 1'b1;
                if (kind_reg == mttm_pkg::KIND_SQUARE)
                begin
                    ph_wdata = {PW'(pf_reg + sstep_reg),
                                PW'(p3_reg + sstep_reg + (sstep_reg << 1)),
                                PW'(p5_reg + sstep_reg + (sstep_reg << 2))};
                end
                else
                begin
                    ph_wdata = {PW'(pf_reg + sstep_reg), p3_reg, p5_reg};
                end
                if (addr_reg == LAST_TRACK)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    addr_next  = addr_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_SUM:
            begin
                acc_next   = acc_reg + prod_reg;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                neg_next   = acc_reg[mttm_pkg::ACC_W-1];
                mag_next   = (acc_reg[mttm_pkg::ACC_W-1] ? 36'(-acc_reg) : 36'(acc_reg))
                             + mttm_pkg::ROUND_HALF;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                // quotient would be 65536 or more: saturated either way
                if (mag_reg >= mttm_pkg::MAG_LIMIT)
                begin
                    done_next    = 1'b1;
                    clipped_next = 1'b1;
                    sample_next  = neg_reg ? mttm_pkg::SAMPLE_MIN : mttm_pkg::SAMPLE_MAX;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    div_go     = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (neg_reg)
                    begin
                        if (div_quot > mttm_pkg::Q_NEG_MAX)
                        begin
                            clipped_next = 1'b1;
                            sample_next  = mttm_pkg::SAMPLE_MIN;
                        end
                        else
                        begin
                            clipped_next = 1'b0;
                            sample_next  = $signed(neg_quot[15:0]);
                        end
                    end
                    else
                    begin
                        if (div_quot > mttm_pkg::Q_POS_MAX)
                        begin
                            clipped_next = 1'b1;
                            sample_next  = mttm_pkg::SAMPLE_MAX;
                        end
                        else
                        begin
                            clipped_next = 1'b0;
                            sample_next  = $signed(div_quot[15:0]);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_cfg_reg <= set_cfg_next;
        kind_reg    <= kind_next;
        gain_reg    <= gain_next;
        sstep_reg   <= sstep_next;
        pf_reg      <= pf_next;
        p3_reg      <= p3_next;
        p5_reg      <= p5_next;
        wsum_reg    <= wsum_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        sample_reg  <= sample_next;
        clipped_reg <= clipped_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign mix_sample = sample_reg;
    assign clipped    = clipped_reg;

endmodule

`default_nettype wire
